// ===== design/chain_node_frame_receiver_defines.svh =====
// Assertion macros shared by the frame receiver modules.
`ifndef CHAIN_NODE_FRAME_RECEIVER_DEFINES_SVH
`define CHAIN_NODE_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define CNFR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("frame receiver assertion failed");

// Expression must never be true outside reset.
`define CNFR_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("frame receiver forbidden condition seen");

`else

`define CNFR_ASSERT(label, clk, rst, prop)
`define CNFR_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ===== design/cnfr_pkg.sv =====
package cnfr_pkg;

  localparam logic [7:0] MAGIC_BYTE     = 8'h77;
  localparam logic [7:0] CMD_PING       = 8'h01;
  localparam logic [7:0] ADDR_BROADCAST = 8'hFF;
  localparam logic [7:0] ADDR_ZERO      = 8'h00;
  localparam logic [7:0] NODE_ADDR_RST  = 8'h01;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Parser phases
  localparam logic [2:0] PH_MAGIC   = 3'd0;
  localparam logic [2:0] PH_FLAGS   = 3'd1;
  localparam logic [2:0] PH_DEST    = 3'd2;
  localparam logic [2:0] PH_SRC     = 3'd3;
  localparam logic [2:0] PH_CMD     = 3'd4;
  localparam logic [2:0] PH_LEN     = 3'd5;
  localparam logic [2:0] PH_PAYLOAD = 3'd6;
  localparam logic [2:0] PH_SUM     = 3'd7;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified event handed from the parser to the result stage.
  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic       response_flag;
    logic [7:0] dest_addr;
    logic [7:0] source_addr;
    logic [7:0] command_code;
    logic [7:0] payload_length;
    logic       magic_ok;
    logic       checksum_ok;
  } cnfr_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } cnfr_qstat_t;

endpackage

// ===== design/cnfr_front.sv =====
module cnfr_front import cnfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  data_byte,
  output logic        push,
  output cnfr_entry_t entry
);

  logic [2:0]  phase;
  logic [7:0]  bytes_left;
  logic        resp_reg;
  logic [7:0]  dest_reg;
  logic [7:0]  src_reg;
  logic [7:0]  cmd_reg;
  logic [7:0]  len_reg;
  logic        magic_reg;
  logic [15:0] sum_acc;
  logic [7:0]  sum_low_byte;
  logic        last_sum_byte;

  assign last_sum_byte = (phase == PH_SUM) && (bytes_left != 8'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_MAGIC;
      bytes_left <= 8'd0;
    end else if (take) begin
      unique case (phase)
        PH_MAGIC: phase <= PH_FLAGS;
        PH_FLAGS: phase <= PH_DEST;
        PH_DEST:  phase <= PH_SRC;
        PH_SRC:   phase <= PH_CMD;
        PH_CMD:   phase <= PH_LEN;
        PH_LEN: begin
          if (data_byte == 8'd0) begin
            phase      <= PH_SUM;
            bytes_left <= 8'd2;
          end else begin
            phase      <= PH_PAYLOAD;
            bytes_left <= data_byte;
          end
        end
        PH_PAYLOAD: begin
          if (bytes_left == 8'd1) begin
            phase      <= PH_SUM;
            bytes_left <= 8'd2;
          end else begin
            bytes_left <= bytes_left - 8'd1;
          end
        end
        PH_SUM: begin
          if (bytes_left == 8'd2) begin
            bytes_left <= 8'd1;
          end else begin
            phase      <= PH_MAGIC;
            bytes_left <= 8'd0;
          end
        end
        default: phase <= PH_MAGIC;
      endcase
    end
  end

  // Header capture and running sum
  always_ff @(posedge clk) begin
    if (take) begin
      case (phase)
        PH_MAGIC:   magic_reg <= (data_byte == MAGIC_BYTE);
        PH_FLAGS:   resp_reg  <= data_byte[0];
        PH_DEST:    dest_reg  <= data_byte;
        PH_SRC:     src_reg   <= data_byte;
        PH_CMD:     cmd_reg   <= data_byte;
        PH_LEN: begin
          len_reg <= data_byte;
          sum_acc <= 16'd0;
        end
        PH_PAYLOAD: sum_acc <= sum_acc + {8'd0, data_byte};
        PH_SUM: begin
          if (bytes_left == 8'd2) sum_low_byte <= data_byte;
        end
        default: ;
      endcase
    end
  end

  assign push = take && ((phase == PH_PAYLOAD) || last_sum_byte);

  always_comb begin
    entry = '0;
    if (phase == PH_PAYLOAD) begin
      entry.kind         = KIND_PAYLOAD;
      entry.payload_byte = data_byte;
    end else begin
      entry.kind           = KIND_SUMMARY;
      entry.response_flag  = resp_reg;
      entry.dest_addr      = dest_reg;
      entry.source_addr    = src_reg;
      entry.command_code   = cmd_reg;
      entry.payload_length = len_reg;
      entry.magic_ok       = magic_reg;
      entry.checksum_ok    = ({data_byte, sum_low_byte} == sum_acc);
    end
  end

endmodule

// ===== design/cnfr_queue.sv =====
`include "chain_node_frame_receiver_defines.svh"

module cnfr_queue import cnfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  cnfr_entry_t push_entry,
  input  logic        pop,
  output cnfr_entry_t head,
  output cnfr_qstat_t stat
);

  cnfr_entry_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  assign head       = slots[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));

  `CNFR_ASSERT_NEVER(a_no_overflow, clk, rst, push && stat.full && !pop)
  `CNFR_ASSERT_NEVER(a_no_underflow, clk, rst, pop && stat.empty)
  `CNFR_ASSERT(a_count_bound, clk, rst, count <= QCNT_W'(QUEUE_DEPTH))

endmodule

// ===== design/cnfr_back.sv =====
module cnfr_back import cnfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  cnfr_entry_t head,
  input  cnfr_qstat_t stat,
  output logic        pop,
  input  logic        out_ready,
  output logic        out_valid,
  output cnfr_entry_t res,
  output logic        res_accept,
  output logic        res_forward,
  output logic        res_ping
);

  logic [7:0] node_address;
  logic       acc_next;
  logic       fwd_next;
  logic       ping_next;
  logic       is_sum;

  always_ff @(posedge clk) begin
    if (rst) node_address <= NODE_ADDR_RST;
    else if (cfg_we) node_address <= cfg_wdata;
  end

  assign is_sum    = (head.kind == KIND_SUMMARY);
  assign acc_next  = is_sum && ((head.dest_addr == node_address) ||
                                (head.dest_addr == ADDR_ZERO) ||
                                (head.dest_addr == ADDR_BROADCAST));
  assign fwd_next  = is_sum && (head.dest_addr != node_address) &&
                     (head.dest_addr != ADDR_ZERO);
  assign ping_next = acc_next && !head.response_flag && (head.command_code == CMD_PING);

  // Load the output register whenever the queue holds an entry and the register is free or being drained
  assign pop = !stat.empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (pop) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res         <= head;
      res_accept  <= acc_next;
      res_forward <= fwd_next;
      res_ping    <= ping_next;
    end
  end

endmodule

// ===== design/chain_node_frame_receiver.sv =====
// Frame receiver for one daisy-chain port.
// Input channel: in_valid / in_ready with data_byte, one received byte per
// transfer. Output channel: out_valid / out_ready with the result fields.
// Each payload byte gives a kind 0 result; the last checksum byte of a frame
// gives a kind 1 summary with header fields, magic and checksum checks and
// the accept / forward / ping decisions. Header bytes and the first checksum
// byte give no result.
// Configuration: cfg_we with cfg_wdata writes node_address (reset value 1).
// Result path: the parser writes each result into the two-entry queue at the
// byte transfer edge, and the result stage loads it from the queue into the
// output register, which then offers it on the output.
// Throughput: one byte per cycle while the queue is not full, set by the byte
// parser and the queue pop path both running every cycle.
// Reset: parser returns to expecting the magic byte, queue and output empty,
// node_address back to 1.
// When the receiver stalls, the result stays in the output register, the
// queue fills, and in_ready drops once the queue is full; bytes that make no
// result are still held off while the queue is full.
`include "chain_node_frame_receiver_defines.svh"

module chain_node_frame_receiver import cnfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [7:0] payload_byte,
  output logic       response_flag,
  output logic [7:0] dest_addr,
  output logic [7:0] source_addr,
  output logic [7:0] command_code,
  output logic [7:0] payload_length,
  output logic       magic_ok,
  output logic       checksum_ok,
  output logic       accept,
  output logic       forward,
  output logic       ping_request
);

  logic        take;
  logic        push;
  logic        pop;
  cnfr_entry_t push_entry;
  cnfr_entry_t head;
  cnfr_entry_t res;
  cnfr_qstat_t stat;

  assign in_ready = !stat.full;
  assign take     = in_valid && in_ready;

  cnfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (data_byte),
    .push      (push),
    .entry     (push_entry)
  );

  cnfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (stat)
  );

  cnfr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .head        (head),
    .stat        (stat),
    .pop         (pop),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .res         (res),
    .res_accept  (accept),
    .res_forward (forward),
    .res_ping    (ping_request)
  );

  assign kind           = res.kind;
  assign payload_byte   = res.payload_byte;
  assign response_flag  = res.response_flag;
  assign dest_addr      = res.dest_addr;
  assign source_addr    = res.source_addr;
  assign command_code   = res.command_code;
  assign payload_length = res.payload_length;
  assign magic_ok       = res.magic_ok;
  assign checksum_ok    = res.checksum_ok;

  `CNFR_ASSERT(a_summary_no_byte, clk, rst, (out_valid && kind) |-> (payload_byte == 8'd0))
  `CNFR_ASSERT(a_payload_no_flags, clk, rst,
    (out_valid && !kind) |-> !(accept || forward || ping_request || magic_ok || checksum_ok))
  `CNFR_ASSERT(a_acc_fwd_bcast, clk, rst,
    (out_valid && accept && forward) |-> (dest_addr == ADDR_BROADCAST) || (dest_addr != ADDR_ZERO))

endmodule

// ===== verif/chain_node_frame_checker.sv =====
`timescale 1ns / 1ps

module chain_node_frame_checker import cnfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       kind,
  input  logic [7:0] payload_byte,
  input  logic       response_flag,
  input  logic [7:0] dest_addr,
  input  logic [7:0] source_addr,
  input  logic [7:0] command_code,
  input  logic [7:0] payload_length,
  input  logic       magic_ok,
  input  logic       checksum_ok,
  input  logic       accept,
  input  logic       forward,
  input  logic       ping_request,
  input  logic       run_done,
  output int         fail_count,
  output int         outstanding
);

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic       response_flag;
    logic [7:0] dest_addr;
    logic [7:0] source_addr;
    logic [7:0] command_code;
    logic [7:0] payload_length;
    logic       magic_ok;
    logic       checksum_ok;
    logic       accept;
    logic       forward;
    logic       ping_request;
  } frame_result_t;

  frame_result_t pending_results[$];

  logic [7:0]  node_addr;
  logic [2:0]  parse_phase;
  logic [7:0]  bytes_to_go;
  logic        resp_bit;
  logic        magic_seen;
  logic [7:0]  dest_hdr;
  logic [7:0]  src_hdr;
  logic [7:0]  cmd_hdr;
  logic [7:0]  len_hdr;
  logic [7:0]  sum_lo;
  logic [15:0] payload_sum;
  logic        leftovers_done;

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 100) $display("%0t: frame check: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Advance the frame parser by one received byte; queue any result it makes.
  task automatic predict_byte(input logic [7:0] b);
    frame_result_t r;
    r = '0;
    case (parse_phase)
      PH_MAGIC: begin
        magic_seen  = (b == MAGIC_BYTE);
        parse_phase = PH_FLAGS;
      end
      PH_FLAGS: begin
        resp_bit    = b[0];
        parse_phase = PH_DEST;
      end
      PH_DEST: begin
        dest_hdr    = b;
        parse_phase = PH_SRC;
      end
      PH_SRC: begin
        src_hdr     = b;
        parse_phase = PH_CMD;
      end
      PH_CMD: begin
        cmd_hdr     = b;
        parse_phase = PH_LEN;
      end
      PH_LEN: begin
        len_hdr     = b;
        payload_sum = '0;
        if (b == 8'd0) begin
          parse_phase = PH_SUM;
          bytes_to_go = 8'd2;
        end else begin
          parse_phase = PH_PAYLOAD;
          bytes_to_go = b;
        end
      end
      PH_PAYLOAD: begin
        payload_sum = payload_sum + 16'(b);
        bytes_to_go = bytes_to_go - 8'd1;
        if (bytes_to_go == 8'd0) begin
          parse_phase = PH_SUM;
          bytes_to_go = 8'd2;
        end
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = b;
        pending_results.push_back(r);
      end
      default: begin
        if (bytes_to_go == 8'd2) begin
          sum_lo      = b;
          bytes_to_go = 8'd1;
        end else begin
          r.kind           = KIND_SUMMARY;
          r.response_flag  = resp_bit;
          r.dest_addr      = dest_hdr;
          r.source_addr    = src_hdr;
          r.command_code   = cmd_hdr;
          r.payload_length = len_hdr;
          r.magic_ok       = magic_seen;
          r.checksum_ok    = ({b, sum_lo} == payload_sum);
          r.accept         = (dest_hdr == node_addr) || (dest_hdr == ADDR_ZERO) ||
                             (dest_hdr == ADDR_BROADCAST);
          r.forward        = (dest_hdr != node_addr) && (dest_hdr != ADDR_ZERO);
          r.ping_request   = r.accept && !resp_bit && (cmd_hdr == CMD_PING);
          pending_results.push_back(r);
          parse_phase = PH_MAGIC;
          bytes_to_go = 8'd0;
        end
      end
    endcase
  endtask

  task automatic check_result();
    frame_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0h byte %0h", kind, payload_byte));
      return;
    end
    want = pending_results.pop_front();
    check_field("kind", kind, want.kind);
    check_field("payload_byte", payload_byte, want.payload_byte);
    check_field("response_flag", response_flag, want.response_flag);
    check_field("dest_addr", dest_addr, want.dest_addr);
    check_field("source_addr", source_addr, want.source_addr);
    check_field("command_code", command_code, want.command_code);
    check_field("payload_length", payload_length, want.payload_length);
    check_field("magic_ok", magic_ok, want.magic_ok);
    check_field("checksum_ok", checksum_ok, want.checksum_ok);
    check_field("accept", accept, want.accept);
    check_field("forward", forward, want.forward);
    check_field("ping_request", ping_request, want.ping_request);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pending_results.delete();
      node_addr      = NODE_ADDR_RST;
      parse_phase    = PH_MAGIC;
      bytes_to_go    = '0;
      resp_bit       = 1'b0;
      magic_seen     = 1'b0;
      dest_hdr       = '0;
      src_hdr        = '0;
      cmd_hdr        = '0;
      len_hdr        = '0;
      sum_lo         = '0;
      payload_sum    = '0;
      leftovers_done = 1'b0;
      fail_count     = 0;
    end else begin
      if (in_valid && in_ready) predict_byte(data_byte);
      if (out_valid && out_ready) check_result();
      // address takes effect after any byte of the same edge
      if (cfg_we) node_addr = cfg_wdata;
      if (run_done && !leftovers_done) begin
        foreach (pending_results[i])
          report_mismatch($sformatf("result never came: kind %0h byte %0h",
                                    pending_results[i].kind, pending_results[i].payload_byte));
        leftovers_done = 1'b1;
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

// ===== verif/chain_node_frame_receiver_tb.sv =====
`timescale 1ns / 1ps

module chain_node_frame_receiver_tb;
  import cnfr_pkg::*;

  typedef logic [7:0] byte_list_t[$];

  localparam int NUM_PHASES  = 8;
  localparam int PHASE_BYTES = 225;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       out_valid;
  logic       out_ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic       response_flag;
  logic [7:0] dest_addr;
  logic [7:0] source_addr;
  logic [7:0] command_code;
  logic [7:0] payload_length;
  logic       magic_ok;
  logic       checksum_ok;
  logic       accept;
  logic       forward;
  logic       ping_request;
  logic       run_done;
  logic       hold_phase;
  int         recv_stall_pct;
  int         fail_count;
  int         outstanding;

  int         send_idle_pct;
  int         bytes_sent;
  int         trk_pos;
  int         trk_left;
  logic [7:0] node_addr_now;

  chain_node_frame_receiver DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .payload_byte(payload_byte),
    .response_flag(response_flag), .dest_addr(dest_addr), .source_addr(source_addr),
    .command_code(command_code), .payload_length(payload_length), .magic_ok(magic_ok),
    .checksum_ok(checksum_ok), .accept(accept), .forward(forward), .ping_request(ping_request)
  );

  chain_node_frame_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .payload_byte(payload_byte),
    .response_flag(response_flag), .dest_addr(dest_addr), .source_addr(source_addr),
    .command_code(command_code), .payload_length(payload_length), .magic_ok(magic_ok),
    .checksum_ok(checksum_ok), .accept(accept), .forward(forward), .ping_request(ping_request),
    .run_done(run_done), .fail_count(fail_count), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side: random stalls, plus one long hold-off while hold_phase is up.
  initial begin
    int held;
    held = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_phase && held < HOLD_CYCLES) begin
        out_ready <= 1'b0;
        held++;
      end else begin
        if (!hold_phase) held = 0;
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    // follow the frame structure so stray bytes can be closed off later
    if (trk_pos < 5) begin
      trk_pos++;
    end else if (trk_pos == 5) begin
      trk_left = int'(b) + 2;
      trk_pos  = 6;
    end else begin
      trk_left--;
      if (trk_left == 0) trk_pos = 0;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // header and first checksum bytes make no result; let them settle too
    repeat (6) @(posedge clk);
  endtask

  task automatic set_node_address(input logic [7:0] addr);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_we <= 1'b0;
    node_addr_now = addr;
  endtask

  function automatic logic [7:0] pick_address();
    case ($urandom_range(3))
      0: return ADDR_ZERO;
      1: return ADDR_BROADCAST;
      2: return 8'($urandom);
      default: return NODE_ADDR_RST;
    endcase
  endfunction

  task automatic send_frame(input logic [7:0] magic, input logic [7:0] flags,
                            input logic [7:0] dest, input logic [7:0] src,
                            input logic [7:0] cmd, input byte_list_t body,
                            input bit bad_sum, input bit swap_addr);
    logic [15:0] check_sum;
    check_sum = '0;
    foreach (body[i]) check_sum = check_sum + 16'(body[i]);
    if (bad_sum) check_sum = check_sum ^ (16'h0001 << $urandom_range(15));
    send_byte(magic);
    send_byte(flags);
    send_byte(dest);
    send_byte(src);
    send_byte(cmd);
    send_byte(8'(body.size()));
    // change the address while the frame is still open
    if (swap_addr) set_node_address(pick_address());
    foreach (body[i]) send_byte(body[i]);
    send_byte(check_sum[7:0]);
    send_byte(check_sum[15:8]);
  endtask

  task automatic send_random_frame();
    byte_list_t body;
    logic [7:0] dest;
    int n;
    case ($urandom_range(4))
      0: dest = node_addr_now;
      1: dest = ADDR_ZERO;
      2: dest = ADDR_BROADCAST;
      3: dest = node_addr_now ^ (8'h01 << $urandom_range(7));
      default: dest = 8'($urandom);
    endcase
    if ($urandom_range(99) < 3) n = $urandom_range(1) ? 255 : $urandom_range(254, 9);
    else n = $urandom_range(8);
    repeat (n) body.push_back(8'($urandom));
    send_frame(($urandom_range(9) == 0) ? 8'($urandom) : MAGIC_BYTE, 8'($urandom), dest,
               8'($urandom), ($urandom_range(2) == 0) ? CMD_PING : 8'($urandom), body,
               $urandom_range(4) == 0, $urandom_range(39) == 0);
  endtask

  task automatic send_random_item();
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(5, 1)) send_byte(8'($urandom));
      // close the broken frame with a zero length so the next one lines up
      while (trk_pos != 0) send_byte((trk_pos == 5) ? 8'h00 : 8'($urandom));
    end else begin
      send_random_frame();
    end
  endtask

  initial begin
    byte_list_t body;
    int send_idle_tbl[4];
    int recv_stall_tbl[4];
    logic [7:0] addr_tbl[NUM_PHASES];
    int p;
    int hold_end;
    send_idle_tbl  = '{0, 64, 0, 19};
    recv_stall_tbl = '{0, 0, 64, 19};
    addr_tbl       = '{8'h01, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'hA5, 8'hFE, 8'h01};
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_wdata      <= 8'h00;
    in_valid       <= 1'b0;
    data_byte      <= 8'h00;
    run_done       <= 1'b0;
    hold_phase     <= 1'b0;
    recv_stall_pct <= 0;
    send_idle_pct = 0;
    bytes_sent    = 0;
    trk_pos       = 0;
    trk_left      = 0;
    node_addr_now = NODE_ADDR_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // ping to the reset address, empty payload
    body = {};
    send_frame(MAGIC_BYTE, 8'h00, NODE_ADDR_RST, 8'h00, CMD_PING, body, 1'b0, 1'b0);
    // bad magic, all-ones header, broadcast response, corrupted sum
    body = {8'hFF};
    send_frame(8'h00, 8'hFF, ADDR_BROADCAST, 8'hFF, 8'hFF, body, 1'b1, 1'b0);
    // stray flag bits, dest zero, ping request
    body = {8'h00, 8'hFF};
    send_frame(MAGIC_BYTE, 8'hFE, ADDR_ZERO, 8'h55, CMD_PING, body, 1'b0, 1'b0);

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) set_node_address(addr_tbl[p]);
      send_idle_pct  = send_idle_tbl[p % 4];
      recv_stall_pct <= recv_stall_tbl[p % 4];
      if (p == 4) begin
        // hold the output off while bytes keep coming, so the input backs up
        hold_phase <= 1'b1;
        hold_end = bytes_sent + 60;
        while (bytes_sent < hold_end) send_random_frame();
        hold_phase <= 1'b0;
      end
      while (bytes_sent < (p + 1) * PHASE_BYTES) send_random_item();
    end

    wait_drained();
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
